>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`endif

>>> rtl/ddo_pkg.sv
// shared types, constants and tables for the wheel odometry block
package ddo_pkg;

  localparam int ENCODER_BITS   = 16;
  localparam int WRAP_MULT_BITS = 32;
  localparam int EXT_BITS       = 48;
  localparam int CORDIC_STEPS   = 24;

  localparam int NUM_W  = 58;
  localparam int DEN_W  = 28;
  localparam int DCNT_W = 6;
  localparam int COR_W  = 50;
  localparam int ZW     = 34;

  localparam logic [0:0] CFG_TICKS_PER_METER = 1'b0;
  localparam logic [0:0] CFG_BASE_WIDTH      = 1'b1;

  localparam logic [29:0] GAIN_Q30       = 30'd652032874;
  localparam logic [29:0] RAD_TO_BAM_Q16 = 30'd683565276;
  localparam logic [25:0] TH_SCALE       = 26'd65536000;
  localparam logic [25:0] D_SCALE        = 26'd65536;
  localparam logic [25:0] US_PER_S       = 26'd1000000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CAPTURE, ST_LOAD, ST_DIVIDE, ST_BAM_MUL, ST_BAM,
    ST_ROT_START, ST_ROT_WAIT, ST_FINISH
  } state_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] s);
    logic [31:0] r;
    unique case (s)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/ddo_unwrap.sv
// one wheel's count unwrap: wrap multiplier update and extended count
module ddo_unwrap import ddo_pkg::*; (
  input  logic signed [ENCODER_BITS-1:0]   raw,
  input  logic        [ENCODER_BITS-1:0]   prev,
  input  logic        [WRAP_MULT_BITS-1:0] mult,
  output logic        [WRAP_MULT_BITS-1:0] mult_next,
  output logic        [EXT_BITS-1:0]       ext_next
);

  localparam int CW = ENCODER_BITS + 3;
  localparam logic signed [CW-1:0] RANGE = CW'(1) <<< ENCODER_BITS;

  logic signed [CW-1:0] cx, px, c5, p5;

  always_comb begin
    cx = CW'(raw);
    px = CW'($signed(prev));
    c5 = (cx <<< 2) + cx;
    p5 = (px <<< 2) + px;
    if (c5 < -RANGE && p5 > RANGE) begin
      mult_next = mult + WRAP_MULT_BITS'(1);
    end else if (c5 > RANGE && p5 < -RANGE) begin
      mult_next = mult - WRAP_MULT_BITS'(1);
    end else begin
      mult_next = mult;
    end
    ext_next = (EXT_BITS'($signed(mult_next)) << ENCODER_BITS) + EXT_BITS'(raw);
  end

endmodule

>>> rtl/ddo_div.sv
// bit-serial restoring divider with sign fixup and 32-bit saturation
module ddo_div import ddo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [31:0] quot
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [NUM_W-1:0]  qsh;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic              neg;
  logic [DEN_W:0]    rem_sh;
  logic              qbit;

  always_comb begin
    rem_sh = {rem, qsh[NUM_W-1]};
    qbit   = (rem_sh >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        qsh  <= req.num;
        rem  <= '0;
        den  <= req.den;
        neg  <= req.neg;
      end else if (busy) begin
        rem <= qbit ? DEN_W'(rem_sh - {1'b0, den}) : DEN_W'(rem_sh);
        qsh <= {qsh[NUM_W-2:0], qbit};
        cnt <= cnt + DCNT_W'(1);
        if (cnt == DCNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // truncation toward zero then clamp
  always_comb begin
    if (neg) begin
      if (qsh > NUM_W'(33'h080000000)) quot = 32'h80000000;
      else                             quot = 32'(-qsh);
    end else begin
      if (qsh > NUM_W'(32'h7FFFFFFF)) quot = 32'h7FFFFFFF;
      else                            quot = qsh[31:0];
    end
  end

endmodule

>>> rtl/ddo_cordic.sv
// iterative rotation cordic, one micro-rotation per cycle
module ddo_cordic import ddo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] distance,
  input  logic        [31:0] angle,
  output logic               done,
  output logic        [31:0] ox,
  output logic        [31:0] oy
);

  logic                    busy;
  logic                    fin;
  logic [4:0]              cnt;
  logic                    flip;
  logic signed [COR_W-1:0] x, y, xs, ys, xf, yf;
  logic signed [ZW-1:0]    z;
  logic                    start_flip;
  logic [31:0]             start_ang;
  logic signed [62:0]      prod;
  logic signed [ZW-1:0]    at;

  always_comb begin
    start_flip = angle[31] ^ angle[30];
    start_ang  = {angle[31] ^ start_flip, angle[30:0]};
    prod       = distance * $signed({1'b0, GAIN_Q30});
    xs         = x >>> cnt;
    ys         = y >>> cnt;
    at         = ZW'(atan_bam(cnt));
    xf         = (flip ? -x : x) + COR_W'(32768);
    yf         = (flip ? -y : y) + COR_W'(32768);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        cnt  <= '0;
        flip <= start_flip;
        z    <= ZW'($signed(start_ang));
        x    <= COR_W'($signed(prod[62:14]));
        y    <= '0;
      end else if (busy && !fin) begin
        if (!z[ZW-1]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'(CORDIC_STEPS - 1)) fin <= 1'b1;
      end else if (busy) begin
        ox   <= xf[47:16];
        oy   <= yf[47:16];
        busy <= 1'b0;
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/diff_drive_odometry.sv
// top level: differential drive odometry with shared divider and cordic
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid / in_ready | opcode, left_count, right_count, elapsed_us
//  out     | out_valid/out_ready | pos_x, pos_y, heading, linear_velocity,
//          |                     | angular_velocity
//  cfg     | cfg_we              | cfg_index, cfg_data
//
// an encoder transfer yields no result
// a tick runs capture, four divisions (load, 58 shift steps, done), the angle
// conversion, a cordic rotation (24 steps, round, done) and the finish state;
// the rotation is skipped when the distance is zero
// in_ready is high only while the sequencer is idle; a held result stalls it
// the result register lets the next item in while a result waits
// synchronous reset restores the register defaults and clears the pose
module diff_drive_odometry import ddo_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     opcode,
  input  logic signed [15:0]       left_count,
  input  logic signed [15:0]       right_count,
  input  logic [23:0]              elapsed_us,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [31:0]       pos_x,
  output logic signed [31:0]       pos_y,
  output logic [31:0]              heading,
  output logic signed [31:0]       linear_velocity,
  output logic signed [31:0]       angular_velocity
);

  state_t state, state_next;

  logic [15:0] tpm;
  logic [11:0] base_w;
  logic [15:0] tpm_eff;
  logic [11:0] base_eff;

  logic [WRAP_MULT_BITS-1:0] l_mult, r_mult, l_mult_next, r_mult_next;
  logic [ENCODER_BITS-1:0]   l_prev, r_prev;
  logic [EXT_BITS-1:0]       l_ext, r_ext, l_ext_next, r_ext_next;
  logic [EXT_BITS-1:0]       l_last, r_last;
  logic                      have_ref;
  logic [31:0]               pose_x, pose_y, head;

  logic [23:0]        el;
  logic signed [31:0] dl, dr;
  logic [1:0]         k;
  logic signed [31:0] d_val, th_val;
  logic [31:0]        lin, ang;
  logic signed [63:0] bam_prod;
  logic [63:0]        bam_sum;
  logic [31:0]        thb;

  logic               in_xfer;
  logic signed [32:0] mul_a;
  logic [25:0]        mul_b;
  logic signed [59:0] mul_p;
  logic [59:0]        mul_mag;
  div_req_t           div_req;
  logic               div_done;
  logic [31:0]        div_q;
  logic               cor_start;
  logic               cor_done;
  logic [31:0]        cor_x, cor_y;
  logic               out_load;

  function automatic logic signed [31:0] sat48(input logic [EXT_BITS-1:0] v);
    logic signed [31:0] r;
    if (v[EXT_BITS-1:31] == '0 || v[EXT_BITS-1:31] == '1) r = $signed(v[31:0]);
    else if (v[EXT_BITS-1])                                r = 32'sh80000000;
    else                                                   r = 32'sh7FFFFFFF;
    return r;
  endfunction

  ddo_unwrap u_unwrap_l (
    .raw(left_count), .prev(l_prev), .mult(l_mult),
    .mult_next(l_mult_next), .ext_next(l_ext_next)
  );

  ddo_unwrap u_unwrap_r (
    .raw(right_count), .prev(r_prev), .mult(r_mult),
    .mult_next(r_mult_next), .ext_next(r_ext_next)
  );

  ddo_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .done(div_done), .quot(div_q)
  );

  ddo_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .distance(d_val),
    .angle(head - thb), .done(cor_done), .ox(cor_x), .oy(cor_y)
  );

  always_comb begin
    tpm_eff  = (tpm == '0) ? 16'd1 : tpm;
    base_eff = (base_w == '0) ? 12'd1 : base_w;
    in_xfer  = in_valid && in_ready;
    out_load = (state == ST_FINISH) && (!out_valid || out_ready);
    bam_sum  = 64'(bam_prod) + 64'h0000000080000000;
  end

  // dividend and divisor of the current division
  always_comb begin
    case (k)
      2'd0: begin
        mul_a = 33'(dl) + 33'(dr);
        mul_b = D_SCALE;
      end
      2'd1: begin
        mul_a = 33'(dr) - 33'(dl);
        mul_b = TH_SCALE;
      end
      2'd2: begin
        mul_a = 33'(d_val);
        mul_b = US_PER_S;
      end
      default: begin
        mul_a = 33'(th_val);
        mul_b = US_PER_S;
      end
    endcase
    mul_p   = mul_a * $signed({1'b0, mul_b});
    mul_mag = mul_p[59] ? 60'(-mul_p) : 60'(mul_p);
    div_req.start = (state == ST_LOAD);
    div_req.neg   = mul_p[59];
    div_req.num   = mul_mag[NUM_W-1:0];
    case (k)
      2'd0:    div_req.den = DEN_W'({tpm_eff, 1'b0});
      2'd1:    div_req.den = DEN_W'(tpm_eff * base_eff);
      default: div_req.den = DEN_W'(el);
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid && opcode) state_next = ST_CAPTURE;
      ST_CAPTURE:   state_next = ST_LOAD;
      ST_LOAD:      state_next = ST_DIVIDE;
      ST_DIVIDE:    if (div_done) state_next = (k == 2'd3) ? ST_BAM_MUL : ST_LOAD;
      ST_BAM_MUL:   state_next = ST_BAM;
      ST_BAM:       state_next = ST_ROT_START;
      ST_ROT_START: state_next = (d_val != '0) ? ST_ROT_WAIT : ST_FINISH;
      ST_ROT_WAIT:  if (cor_done) state_next = ST_FINISH;
      ST_FINISH:    if (!out_valid || out_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    cor_start = (state == ST_ROT_START) && (d_val != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tpm       <= 16'd95;
      base_w    <= 12'd135;
      l_mult    <= '0;
      r_mult    <= '0;
      l_prev    <= '0;
      r_prev    <= '0;
      l_ext     <= '0;
      r_ext     <= '0;
      l_last    <= '0;
      r_last    <= '0;
      have_ref  <= 1'b0;
      pose_x    <= '0;
      pose_y    <= '0;
      head      <= '0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TICKS_PER_METER: tpm    <= cfg_data;
          CFG_BASE_WIDTH:      base_w <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (in_xfer && !opcode) begin
        l_mult <= l_mult_next;
        r_mult <= r_mult_next;
        l_ext  <= l_ext_next;
        r_ext  <= r_ext_next;
        l_prev <= left_count;
        r_prev <= right_count;
      end
      if (in_xfer && opcode) begin
        el <= (elapsed_us == '0) ? 24'd1 : elapsed_us;
      end
      if (state == ST_CAPTURE) begin
        dl       <= have_ref ? sat48(l_ext - l_last) : 32'sd0;
        dr       <= have_ref ? sat48(r_ext - r_last) : 32'sd0;
        l_last   <= l_ext;
        r_last   <= r_ext;
        have_ref <= 1'b1;
        k        <= '0;
      end
      if (state == ST_DIVIDE && div_done) begin
        case (k)
          2'd0:    d_val  <= $signed(div_q);
          2'd1:    th_val <= $signed(div_q);
          2'd2:    lin    <= div_q;
          default: ang    <= div_q;
        endcase
        k <= k + 2'd1;
      end
      if (state == ST_BAM_MUL) begin
        bam_prod <= 64'(th_val * $signed({1'b0, RAD_TO_BAM_Q16}));
      end
      if (state == ST_BAM) begin
        thb <= bam_sum[63:32];
      end
      if (state == ST_ROT_WAIT && cor_done) begin
        pose_x <= pose_x + cor_x;
        pose_y <= pose_y + cor_y;
      end
      if (out_load) begin
        out_valid        <= 1'b1;
        pos_x            <= $signed(pose_x);
        pos_y            <= $signed(pose_y);
        heading          <= head + thb;
        head             <= head + thb;
        linear_velocity  <= $signed(lin);
        angular_velocity <= $signed(ang);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/ddo_checker.sv
// port-level checker for the odometry block and its bind
`include "assert_macros.svh"

module ddo_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               opcode,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] pos_x,
  input logic [31:0]        heading
);

  `ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, rst, !out_valid)
  `ASSERT_NEXT(a_out_held, clk, rst, out_valid && !out_ready,
    out_valid && $stable(pos_x) && $stable(heading))
  `ASSERT_NEXT(a_tick_busy, clk, rst, in_valid && in_ready && opcode, !in_ready)
  `ASSERT_NEXT(a_encoder_no_result, clk, rst, in_valid && in_ready && !opcode,
    !$rose(out_valid))

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (.*);

>>> sim/tb_diff_drive_odometry.sv
// self-checking testbench for the differential drive odometry block
`timescale 1ns / 100ps

module tb_diff_drive_odometry import ddo_pkg::*;;

  localparam logic OP_ENCODER = 1'b0;
  localparam logic OP_TICK    = 1'b1;
  localparam int   SETTLE     = 400;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [31:0]        hd;
    logic signed [31:0] lv;
    logic signed [31:0] av;
  } pose_t;

  typedef struct {
    logic               op;
    logic signed [15:0] l;
    logic signed [15:0] r;
    logic [23:0]        el;
    bit                 typed;
    pose_t              want;
  } row_t;

  localparam logic [31:0] ANGLE_STEP [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  logic clk, rst;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_ready, opcode;
  logic signed [15:0] left_count, right_count;
  logic [23:0] elapsed_us;
  logic out_valid, out_ready;
  logic signed [31:0] pos_x, pos_y, linear_velocity, angular_velocity;
  logic [31:0] heading;

  diff_drive_odometry dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .left_count(left_count), .right_count(right_count), .elapsed_us(elapsed_us),
    .out_valid(out_valid), .out_ready(out_ready), .pos_x(pos_x), .pos_y(pos_y),
    .heading(heading), .linear_velocity(linear_velocity),
    .angular_velocity(angular_velocity)
  );

  // odometry model state
  logic [15:0] tpm_reg;
  logic [11:0] base_reg;
  logic [31:0] wrap_mult [2];
  logic [15:0] prev_raw [2];
  logic [47:0] ext_count [2];
  logic [47:0] tick_count [2];
  bit          have_ref;
  logic [31:0] x_acc, y_acc, hd_acc;

  pose_t pose_q [$];
  int    errors;
  bit    no_idle;
  int    stall;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sx48(logic [47:0] v);
    return {{16{v[47]}}, v};
  endfunction

  function automatic void unwrap(int w, logic signed [15:0] raw);
    longint c, p;
    logic [47:0] e;
    c = raw;
    p = longint'(signed'(prev_raw[w]));
    if (5 * c < -65536 && 5 * p > 65536) wrap_mult[w] = wrap_mult[w] + 1;
    else if (5 * c > 65536 && 5 * p < -65536) wrap_mult[w] = wrap_mult[w] - 1;
    e = 48'(c + (longint'(signed'(wrap_mult[w])) <<< 16));
    ext_count[w] = e;
    prev_raw[w] = raw;
  endfunction

  function automatic void rotate(longint d, logic [31:0] ang, output longint ox,
                                 output longint oy);
    longint x, y, z, xs, ys;
    logic [31:0] t, a;
    bit flip;
    a = ang;
    t = a + 32'h40000000;
    flip = t[31];
    if (flip) a = a + 32'h80000000;
    z = longint'(signed'(a));
    x = (d * 64'sd652032874) >>> 14;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(ANGLE_STEP[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(ANGLE_STEP[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    ox = (x + 32768) >>> 16;
    oy = (y + 32768) >>> 16;
  endfunction

  function automatic bit odometry_step(logic op, logic signed [15:0] l,
                                       logic signed [15:0] r, logic [23:0] elu,
                                       output pose_t res);
    longint dl, dr, tpm, base, el, d, th, cx, cy, bam;
    logic [31:0] thb;
    res = '0;
    if (op == OP_ENCODER) begin
      unwrap(0, l);
      unwrap(1, r);
      return 1'b0;
    end
    dl = 0;
    dr = 0;
    if (have_ref) begin
      dl = sat32(sx48(ext_count[0] - tick_count[0]));
      dr = sat32(sx48(ext_count[1] - tick_count[1]));
    end
    tick_count[0] = ext_count[0];
    tick_count[1] = ext_count[1];
    have_ref = 1'b1;
    tpm = (tpm_reg != 0) ? longint'(tpm_reg) : 1;
    base = (base_reg != 0) ? longint'(base_reg) : 1;
    el = (elu != 0) ? longint'(elu) : 1;
    d = sat32((dl + dr) * 65536 / (2 * tpm));
    th = sat32((dr - dl) * 65536000 / (tpm * base));
    bam = (th * 64'sd683565276 + 64'sd2147483648) >>> 32;
    thb = bam[31:0];
    if (d != 0) begin
      rotate(d, hd_acc - thb, cx, cy);
      x_acc = x_acc + cx[31:0];
      y_acc = y_acc + cy[31:0];
    end
    hd_acc = hd_acc + thb;
    res.px = x_acc;
    res.py = y_acc;
    res.hd = hd_acc;
    res.lv = 32'(sat32(d * 1000000 / el));
    res.av = 32'(sat32(th * 1000000 / el));
    return 1'b1;
  endfunction

  task automatic idle_gap();
    int g, k;
    k = $urandom_range(0, 99);
    if (no_idle || k < 60) g = 0;
    else if (k < 95) g = $urandom_range(1, 3);
    else g = $urandom_range(20, 200);
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // drive one transfer on the input channel, starting at a falling edge
  task automatic send(logic op, logic signed [15:0] l, logic signed [15:0] r,
                      logic [23:0] el, bit typed, pose_t want);
    pose_t res;
    idle_gap();
    in_valid = 1'b1;
    opcode = op;
    left_count = l;
    right_count = r;
    elapsed_us = el;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    if (odometry_step(op, l, r, el, res)) pose_q.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [0:0] idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    if (idx == CFG_TICKS_PER_METER) tpm_reg = val;
    else base_reg = val[11:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // result channel: random stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall <= 0;
    end else if (stall > 0) begin
      out_ready <= 1'b0;
      stall <= stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (!no_idle) begin
        if ($urandom_range(0, 99) < 30) stall <= $urandom_range(1, 4);
        else if ($urandom_range(0, 99) < 3) stall <= $urandom_range(30, 300);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pose_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer at %0t", $time);
      end else begin
        pose_t w;
        w = pose_q.pop_front();
        if (w.px !== pos_x || w.py !== pos_y || w.hd !== heading ||
            w.lv !== linear_velocity || w.av !== angular_velocity) begin
          errors++;
          if (errors <= 10)
            $display("mismatch %0t exp %h %h %h %h %h got %h %h %h %h %h",
                     $time, w.px, w.py, w.hd, w.lv, w.av, pos_x, pos_y, heading,
                     linear_velocity, angular_velocity);
        end
      end
    end
  end

  initial begin
    row_t rows [$];
    row_t rw;
    pose_t none;
    int lw, rwc, k, n;
    logic [15:0] tpm_set [6];
    logic [15:0] base_set [6];
    logic [23:0] el;

    none = '0;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; opcode = OP_ENCODER;
    left_count = '0; right_count = '0; elapsed_us = '0;
    errors = 0; no_idle = 1'b0;
    tpm_reg = 16'd95; base_reg = 12'd135;
    wrap_mult = '{default: '0}; prev_raw = '{default: '0};
    ext_count = '{default: '0}; tick_count = '{default: '0};
    have_ref = 1'b0; x_acc = '0; y_acc = '0; hd_acc = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows; the first tick after reset has no reference and reports zeros
    rw = '{OP_TICK, 16'sd0, 16'sd0, 24'd1000, 1'b1, none};      rows.push_back(rw);
    rw = '{OP_ENCODER, 16'sd100, 16'sd100, 24'd0, 1'b0, none};  rows.push_back(rw);
    rw = '{OP_TICK, 16'sd0, 16'sd0, 24'd10000, 1'b0, none};     rows.push_back(rw);
    rw = '{OP_ENCODER, 16'sd32767, -16'sd32768, 24'hFFFFFF, 1'b0, none}; rows.push_back(rw);
    rw = '{OP_TICK, -16'sd1, -16'sd1, 24'd0, 1'b0, none};       rows.push_back(rw);
    rw = '{OP_ENCODER, -16'sd32768, 16'sd32767, 24'd5, 1'b0, none}; rows.push_back(rw);
    rw = '{OP_TICK, 16'sd0, 16'sd0, 24'hFFFFFF, 1'b0, none};    rows.push_back(rw);
    rw = '{OP_TICK, 16'sd0, 16'sd0, 24'd1, 1'b0, none};         rows.push_back(rw);
    rw = '{OP_ENCODER, 16'sd20000, -16'sd20000, 24'd0, 1'b0, none}; rows.push_back(rw);
    rw = '{OP_ENCODER, -16'sd20000, 16'sd20000, 24'd0, 1'b0, none}; rows.push_back(rw);
    rw = '{OP_TICK, 16'sd0, 16'sd0, 24'd20000, 1'b0, none};     rows.push_back(rw);
    rw = '{OP_ENCODER, 16'sd5000, 16'sd7000, 24'd0, 1'b0, none}; rows.push_back(rw);
    rw = '{OP_TICK, 16'sd0, 16'sd0, 24'd20000, 1'b0, none};     rows.push_back(rw);
    rw = '{OP_ENCODER, 16'sd5000, 16'sd7000, 24'd0, 1'b0, none}; rows.push_back(rw);
    rw = '{OP_TICK, 16'sd0, 16'sd0, 24'd777, 1'b0, none};       rows.push_back(rw);
    foreach (rows[i]) send(rows[i].op, rows[i].l, rows[i].r, rows[i].el,
                           rows[i].typed, rows[i].want);

    tpm_set = '{16'd95, 16'd1, 16'd65535, 16'd0, 16'($urandom_range(1, 65535)), 16'd1000};
    base_set = '{16'd135, 16'd1, 16'd4095, 16'd0, 16'($urandom_range(1, 4095)), 16'd300};
    lw = 0;
    rwc = 0;
    for (int p = 0; p < 6; p++) begin
      drain();
      cfg_write(CFG_TICKS_PER_METER, tpm_set[p]);
      cfg_write(CFG_BASE_WIDTH, base_set[p]);
      no_idle = (p == 3);
      for (n = 0; n < 185; n++) begin
        k = $urandom_range(0, 99);
        if (k < 25) begin
          k = $urandom_range(0, 99);
          if (k < 80) el = 24'($urandom_range(1, 100000));
          else if (k < 97) el = 24'($urandom());
          else el = 24'd0;
          send(OP_TICK, 16'($urandom()), 16'($urandom()), el, 1'b0, none);
        end else begin
          k = $urandom_range(0, 99);
          if (k < 5) begin
            lw = $signed(16'($urandom()));
            rwc = $signed(16'($urandom()));
          end else if (k < 20) begin
            lw = lw + $urandom_range(0, 8000) - 4000;
            rwc = rwc + $urandom_range(0, 8000) - 4000;
          end else begin
            lw = lw + $urandom_range(0, 600) - 300;
            rwc = rwc + $urandom_range(0, 600) - 300;
          end
          send(OP_ENCODER, 16'(lw), 16'(rwc), 24'($urandom()), 1'b0, none);
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
